// ===== sv/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and constants for the Intel HEX record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

  // Default depth of the record data buffer, in bytes
  localparam int MAX_DATA_DEF = 32;

  // Bytes in a record frame: count, two address bytes, type, checksum
  localparam int FRAME_LEN = 5;

  // Line counters saturate here
  localparam int CNT_W = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Record types
  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_EXT_SEG   = 8'h02;
  localparam logic [7:0] REC_START_SEG = 8'h03;
  localparam logic [7:0] REC_EXT_LIN   = 8'h04;
  localparam logic [7:0] REC_START_LIN = 8'h05;

  // Result status codes
  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NO_START  = 3'd1,
    STS_BAD_CHAR  = 3'd2,
    STS_BAD_LEN   = 3'd3,
    STS_BAD_SUM   = 3'd4,
    STS_BAD_TYPE  = 3'd5,
    STS_MALFORMED = 3'd6,
    STS_AFTER_EOF = 3'd7
  } status_t;

  // Where the current line stands
  typedef enum logic [1:0] {
    PH_LEAD    = 2'd0,  // skipping leading whitespace
    PH_BODY    = 2'd1,  // after the start code
    PH_NOSTART = 2'd2,  // first non-space was not ':'
    PH_NUL     = 2'd3   // text ended by a NUL
  } line_phase_t;

  // Control sequencer
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,  // taking characters
    ST_READ = 2'd1,  // walking the data buffer
    ST_EMIT = 2'd2   // single status result pending
  } ctl_state_t;

endpackage

// ===== sv/ihex_in_if.sv =====
// ----------------------------------------------------------------------------
// ihex_in_if
// Character channel: one text character or an end-of-line mark per beat.
// ----------------------------------------------------------------------------
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_line;

  modport source (output valid, output character, output end_of_line, input ready);
  modport sink   (input valid, input character, input end_of_line, output ready);
endinterface

// ===== sv/ihex_out_if.sv =====
// ----------------------------------------------------------------------------
// ihex_out_if
// Result channel: one data byte or one status result per beat.
// ----------------------------------------------------------------------------
interface ihex_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  record_type;
  logic [7:0]  record_length;
  logic [31:0] record_address;
  logic [7:0]  byte_index;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic [31:0] start_address;
  logic        start_valid;
  logic        eof_seen;
  logic        last;

  modport source (
    output valid, output status, output record_type, output record_length,
    output record_address, output byte_index, output data_byte, output byte_valid,
    output start_address, output start_valid, output eof_seen, output last,
    input ready
  );
  modport sink (
    input valid, input status, input record_type, input record_length,
    input record_address, input byte_index, input data_byte, input byte_valid,
    input start_address, input start_valid, input eof_seen, input last,
    output ready
  );
endinterface

// ===== sv/intel_hex_record_parser_unit.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_parser_unit
// Intel HEX line parser: characters in, data bytes or record status out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per character; a beat with end_of_line set closes
//   the line (its character is ignored). Character beats are taken one per
//   cycle and give no result. Data bytes are stored in a one-port-write,
//   one-port-read buffer with a registered read.
//   At end of line the record is checked. A good data record with a nonzero
//   length gives one result per data byte on out_ch, the last one flagged;
//   everything else gives a single status result with last set.
//   A status result passes through the emit state into the output register;
//   extended-address and start-address records first read two or four
//   buffer bytes. Data bytes follow one per cycle while out_ch does not
//   stall, limited by the buffer read port.
//   in_ch.ready drops from the end-of-line beat until the last result of
//   the line has entered the output register; characters of the next line
//   are taken while that result still waits.
//   A stall on out_ch holds the output register and the data-byte walk.
//   Reset (rst_n low, synchronous) clears the line state, the address base,
//   the start address and the EOF flag. The data buffer is not cleared.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_unit #(
  parameter int MAX_DATA = ihex_pkg::MAX_DATA_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ihex_in_if.sink           in_ch,
  ihex_out_if.source        out_ch
);

  localparam int AW = $clog2(MAX_DATA);
  localparam int CW = $clog2(MAX_DATA + 1);
  localparam int CNTW = ihex_pkg::CNT_W;
  localparam logic [CNTW-1:0] MIN_LEN = CNTW'(2 * ihex_pkg::FRAME_LEN);
  localparam logic [CNTW-1:0] MAX_BYTES = CNTW'(ihex_pkg::FRAME_LEN + MAX_DATA);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [CNTW-1:0] sat_add(input logic [CNTW-1:0] a,
                                               input logic [CNTW-1:0] b);
    logic [CNTW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, ihex_pkg::CNT_MAX}) ? ihex_pkg::CNT_MAX : s[CNTW-1:0];
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  ihex_pkg::ctl_state_t  state_r, state_nxt;
  ihex_pkg::line_phase_t phase_r, phase_nxt;
  logic [CNTW-1:0] body_cnt_r, body_cnt_nxt;
  logic [CNTW-1:0] trail_r, trail_nxt;
  logic            bad_r, bad_nxt;
  logic [3:0]      hnib_r, hnib_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [31:0]     header_r, header_nxt;
  logic [31:0]     base_r, base_nxt;
  logic [31:0]     start_r, start_nxt;
  logic            start_seen_r, start_seen_nxt;
  logic            eof_r, eof_nxt;

  // buffer walk
  logic [CW-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [CW-1:0]   rd_len_r, rd_len_nxt;
  logic            rd_ext_r, rd_ext_nxt;   // walk feeds the address accumulator
  logic [31:0]     acc_r, acc_nxt;

  // result held for the emit step
  ihex_pkg::status_t em_status_r, em_status_nxt;
  logic [7:0]      em_type_r, em_type_nxt;
  logic [7:0]      em_len_r, em_len_nxt;
  logic [31:0]     em_addr_r, em_addr_nxt;

  // output register
  logic            out_valid_r;
  ihex_pkg::status_t out_status_r;
  logic [7:0]      out_type_r, out_len_r, out_idx_r, out_byte_r;
  logic [31:0]     out_addr_r, out_start_r;
  logic            out_bv_r, out_sv_r, out_eof_r, out_last_r;

  logic            load;
  ihex_pkg::status_t ld_status;
  logic [7:0]      ld_type, ld_len, ld_idx, ld_byte;
  logic [31:0]     ld_addr;
  logic            ld_bv, ld_last;

  // data buffer
  logic [7:0]      mem [MAX_DATA];
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic [7:0]      rd_data_r;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic in_acc, slot_free;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ihex_pkg::ST_IDLE);

  // --------------------------------------------------------------------------
  // Character decode temporaries
  // --------------------------------------------------------------------------
  logic [4:0]      nib_info;
  logic            is_ws;
  logic [CNTW-1:0] c_pos;
  logic [7:0]      c_byte;
  logic [8:0]      c_idx, c_widx;
  assign nib_info = hex_nib(in_ch.character);
  assign is_ws = (in_ch.character inside {8'h20, 8'h09, 8'h0D, 8'h0A});

  // --------------------------------------------------------------------------
  // Line-end checks, in file order
  // --------------------------------------------------------------------------
  logic [7:0]      declared, rtype;
  logic [15:0]     offset;
  logic [8:0]      nbytes;
  logic            chk_fail;
  ihex_pkg::status_t chk_status;
  logic [31:0]     data_addr;

  assign declared  = header_r[31:24];
  assign offset    = header_r[23:8];
  assign rtype     = header_r[7:0];
  assign nbytes    = body_cnt_r[CNTW-1:1];
  assign data_addr = base_r + {16'h0000, offset};

  always_comb begin
    chk_fail   = 1'b1;
    chk_status = ihex_pkg::STS_OK;
    if (phase_r == ihex_pkg::PH_LEAD || phase_r == ihex_pkg::PH_NOSTART) begin
      chk_status = ihex_pkg::STS_NO_START;
    end else if (body_cnt_r < MIN_LEN || body_cnt_r[0]) begin
      chk_status = ihex_pkg::STS_BAD_LEN;
    end else if ({1'b0, nbytes} > MAX_BYTES) begin
      chk_status = ihex_pkg::STS_BAD_LEN;
    end else if (bad_r) begin
      chk_status = ihex_pkg::STS_BAD_CHAR;
    end else if (nbytes != (9'(declared) + 9'(ihex_pkg::FRAME_LEN))) begin
      chk_status = ihex_pkg::STS_BAD_LEN;
    end else if (sum_r != 8'h00) begin
      chk_status = ihex_pkg::STS_BAD_SUM;
    end else if (eof_r) begin
      chk_status = ihex_pkg::STS_AFTER_EOF;
    end else begin
      chk_fail = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    body_cnt_nxt   = body_cnt_r;
    trail_nxt      = trail_r;
    bad_nxt        = bad_r;
    hnib_nxt       = hnib_r;
    sum_nxt        = sum_r;
    header_nxt     = header_r;
    base_nxt       = base_r;
    start_nxt      = start_r;
    start_seen_nxt = start_seen_r;
    eof_nxt        = eof_r;
    rd_cnt_nxt     = rd_cnt_r;
    rd_len_nxt     = rd_len_r;
    rd_ext_nxt     = rd_ext_r;
    acc_nxt        = acc_r;
    em_status_nxt  = em_status_r;
    em_type_nxt    = em_type_r;
    em_len_nxt     = em_len_r;
    em_addr_nxt    = em_addr_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = 8'h00;
    load           = 1'b0;
    ld_status      = ihex_pkg::STS_OK;
    ld_type        = 8'h00;
    ld_len         = 8'h00;
    ld_addr        = 32'h0;
    ld_idx         = 8'h00;
    ld_byte        = 8'h00;
    ld_bv          = 1'b0;
    ld_last        = 1'b0;
    c_pos          = body_cnt_r;
    c_byte         = {hnib_r, nib_info[3:0]};
    c_idx          = body_cnt_r[CNTW-1:1];
    c_widx         = body_cnt_r[CNTW-1:1] - 9'd4;

    case (state_r)
      ihex_pkg::ST_IDLE: begin
        if (in_acc && in_ch.end_of_line) begin
          // close the line and decide what it yields
          phase_nxt     = ihex_pkg::PH_LEAD;
          body_cnt_nxt  = '0;
          trail_nxt     = '0;
          bad_nxt       = 1'b0;
          hnib_nxt      = 4'h0;
          sum_nxt       = 8'h00;
          header_nxt    = 32'h0;
          rd_cnt_nxt    = '0;
          em_status_nxt = ihex_pkg::STS_OK;
          em_type_nxt   = 8'h00;
          em_len_nxt    = 8'h00;
          em_addr_nxt   = 32'h0;
          state_nxt     = ihex_pkg::ST_EMIT;
          if (chk_fail) begin
            em_status_nxt = chk_status;
          end else begin
            case (rtype)
              ihex_pkg::REC_DATA: begin
                em_addr_nxt = data_addr;
                if (declared != 8'h00) begin
                  em_len_nxt = declared;
                  rd_len_nxt = CW'(declared);
                  rd_ext_nxt = 1'b0;
                  state_nxt  = ihex_pkg::ST_READ;
                end
              end
              ihex_pkg::REC_EOF: begin
                em_type_nxt = rtype;
                em_len_nxt  = declared;
                if (declared != 8'h00) begin
                  em_status_nxt = ihex_pkg::STS_MALFORMED;
                end else begin
                  eof_nxt = 1'b1;
                end
              end
              ihex_pkg::REC_EXT_SEG, ihex_pkg::REC_EXT_LIN: begin
                em_type_nxt = rtype;
                em_len_nxt  = declared;
                if (declared != 8'd2) begin
                  em_status_nxt = ihex_pkg::STS_MALFORMED;
                end else begin
                  rd_len_nxt = CW'(2);
                  rd_ext_nxt = 1'b1;
                  state_nxt  = ihex_pkg::ST_READ;
                end
              end
              ihex_pkg::REC_START_SEG, ihex_pkg::REC_START_LIN: begin
                em_type_nxt = rtype;
                em_len_nxt  = declared;
                if (declared != 8'd4) begin
                  em_status_nxt = ihex_pkg::STS_MALFORMED;
                end else begin
                  rd_len_nxt = CW'(4);
                  rd_ext_nxt = 1'b1;
                  state_nxt  = ihex_pkg::ST_READ;
                end
              end
              default: begin
                em_type_nxt   = rtype;
                em_len_nxt    = declared;
                em_status_nxt = ihex_pkg::STS_BAD_TYPE;
              end
            endcase
          end
        end else if (in_acc) begin
          case (phase_r)
            ihex_pkg::PH_LEAD: begin
              if (in_ch.character == ihex_pkg::CH_COLON) begin
                phase_nxt = ihex_pkg::PH_BODY;
              end else if (!is_ws) begin
                phase_nxt = ihex_pkg::PH_NOSTART;
              end
            end
            ihex_pkg::PH_BODY: begin
              if (in_ch.character == ihex_pkg::CH_NUL) begin
                phase_nxt = ihex_pkg::PH_NUL;
              end else if (is_ws) begin
                trail_nxt = sat_add(trail_r, CNTW'(1));
              end else begin
                // spaces followed by text count as bad body characters
                if (trail_r != '0) begin
                  bad_nxt = 1'b1;
                  c_pos   = sat_add(body_cnt_r, trail_r);
                  trail_nxt = '0;
                end
                if (!nib_info[4]) bad_nxt = 1'b1;
                c_byte = {hnib_r, nib_info[3:0]};
                c_idx  = c_pos[CNTW-1:1];
                c_widx = c_idx - 9'd4;
                if (!c_pos[0]) begin
                  hnib_nxt = nib_info[3:0];
                end else begin
                  if (c_idx < 9'd4) begin
                    case (c_idx[1:0])
                      2'd0:    header_nxt[31:24] = c_byte;
                      2'd1:    header_nxt[23:16] = c_byte;
                      2'd2:    header_nxt[15:8]  = c_byte;
                      default: header_nxt[7:0]   = c_byte;
                    endcase
                  end else if (c_widx < 9'(MAX_DATA)) begin
                    wr_en   = 1'b1;
                    wr_addr = c_widx[AW-1:0];
                    wr_data = c_byte;
                  end
                  sum_nxt = sum_r + c_byte;
                end
                body_cnt_nxt = sat_add(c_pos, CNTW'(1));
              end
            end
            default: ;  // no start code, or text ended by NUL
          endcase
        end
      end

      ihex_pkg::ST_READ: begin
        if (rd_ext_r) begin
          // address / start records: gather bytes big-endian
          acc_nxt    = {acc_r[23:0], rd_data_r};
          rd_cnt_nxt = rd_cnt_r + CW'(1);
          if (rd_cnt_r + CW'(1) == rd_len_r) begin
            state_nxt = ihex_pkg::ST_EMIT;
            case (em_type_r)
              ihex_pkg::REC_EXT_LIN: base_nxt = {acc_nxt[15:0], 16'h0000};
              ihex_pkg::REC_EXT_SEG: base_nxt = {12'h000, acc_nxt[15:0], 4'h0};
              default: begin
                start_nxt      = acc_nxt;
                start_seen_nxt = 1'b1;
              end
            endcase
          end
        end else if (slot_free) begin
          load       = 1'b1;
          ld_status  = ihex_pkg::STS_OK;
          ld_type    = em_type_r;
          ld_len     = em_len_r;
          ld_addr    = em_addr_r;
          ld_idx     = 8'(rd_cnt_r);
          ld_byte    = rd_data_r;
          ld_bv      = 1'b1;
          ld_last    = (rd_cnt_r + CW'(1) == rd_len_r);
          rd_cnt_nxt = rd_cnt_r + CW'(1);
          if (ld_last) state_nxt = ihex_pkg::ST_IDLE;
        end
      end

      ihex_pkg::ST_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_status = em_status_r;
          ld_type   = em_type_r;
          ld_len    = em_len_r;
          ld_addr   = em_addr_r;
          ld_last   = 1'b1;
          state_nxt = ihex_pkg::ST_IDLE;
        end
      end

      default: state_nxt = ihex_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ihex_pkg::ST_IDLE;
      phase_r      <= ihex_pkg::PH_LEAD;
      body_cnt_r   <= '0;
      trail_r      <= '0;
      bad_r        <= 1'b0;
      hnib_r       <= 4'h0;
      sum_r        <= 8'h00;
      header_r     <= 32'h0;
      base_r       <= 32'h0;
      start_r      <= 32'h0;
      start_seen_r <= 1'b0;
      eof_r        <= 1'b0;
      rd_cnt_r     <= '0;
      rd_len_r     <= '0;
      rd_ext_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      body_cnt_r   <= body_cnt_nxt;
      trail_r      <= trail_nxt;
      bad_r        <= bad_nxt;
      hnib_r       <= hnib_nxt;
      sum_r        <= sum_nxt;
      header_r     <= header_nxt;
      base_r       <= base_nxt;
      start_r      <= start_nxt;
      start_seen_r <= start_seen_nxt;
      eof_r        <= eof_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      rd_len_r     <= rd_len_nxt;
      rd_ext_r     <= rd_ext_nxt;
      out_valid_r  <= load || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    em_status_r <= em_status_nxt;
    em_type_r   <= em_type_nxt;
    em_len_r    <= em_len_nxt;
    em_addr_r   <= em_addr_nxt;
    if (load) begin
      out_status_r <= ld_status;
      out_type_r   <= ld_type;
      out_len_r    <= ld_len;
      out_addr_r   <= ld_addr;
      out_idx_r    <= ld_idx;
      out_byte_r   <= ld_byte;
      out_bv_r     <= ld_bv;
      out_start_r  <= start_r;
      out_sv_r     <= start_seen_r;
      out_eof_r    <= eof_r;
      out_last_r   <= ld_last;
    end
  end

  // Data buffer. Writes happen only while characters are taken, reads are
  // used only after the line closes, so no same-entry overlap occurs.
  // Read address follows the next walk count: data tracks rd_cnt_r.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_cnt_nxt[AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.record_type    = out_type_r;
  assign out_ch.record_length  = out_len_r;
  assign out_ch.record_address = out_addr_r;
  assign out_ch.byte_index     = out_idx_r;
  assign out_ch.data_byte      = out_byte_r;
  assign out_ch.byte_valid     = out_bv_r;
  assign out_ch.start_address  = out_start_r;
  assign out_ch.start_valid    = out_sv_r;
  assign out_ch.eof_seen       = out_eof_r;
  assign out_ch.last           = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ihex_pkg::ST_READ |-> rd_cnt_r < rd_len_r)
    else $error("buffer walk ran past record length");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    load && ld_last |=> state_r == ihex_pkg::ST_IDLE)
    else $error("final result loaded but sequencer not idle");

  a_byte_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bv_r |-> out_status_r == ihex_pkg::STS_OK)
    else $error("data byte carried with error status");

  a_eof_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(eof_r))
    else $error("EOF flag cleared outside reset");

endmodule
